// ----- hw/rtl/fibonacci_prefix_sum_mod_defines.svh -----
// Assertion helpers shared by the RTL.
`ifndef FIBONACCI_PREFIX_SUM_MOD_DEFINES_SVH
`define FIBONACCI_PREFIX_SUM_MOD_DEFINES_SVH

// Antecedent implies consequent on the next cycle.
`define FPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define FPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/fps_pkg.sv -----
`timescale 1ns / 1ps
package fps_pkg;
    localparam int unsigned DEF_EXP_BITS = 63;
    localparam int unsigned IN_W = 63;
    localparam int unsigned OUT_W = 30;
    localparam logic [29:0] MOD_P = 30'd1000000007;

    // Datapath command from the controller.
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INIT = 2'd1,
        OP_MUL  = 2'd2,  // acc = acc * base
        OP_SQR  = 2'd3   // base = base * base
    } op_t;

    typedef struct packed {
        op_t  op;
        logic start;   // launch op
        logic fin;     // final vector reduction
    } fps_cmd_t;

    typedef struct packed {
        logic busy;
    } fps_sts_t;
endpackage

// ----- hw/rtl/fps_datapath.sv -----
`timescale 1ns / 1ps
`include "fibonacci_prefix_sum_mod_defines.svh"
module fps_datapath
(
    input  logic            clk,
    input  logic            rst_n,
    input  fps_pkg::fps_cmd_t cmd,
    output fps_pkg::fps_sts_t sts,
    output logic [29:0]     result
);
    import fps_pkg::*;

    // Barrett constant floor(2^60 / p), and two and three times the modulus.
    localparam logic [30:0] BAR_M  = 31'd1152921496;
    localparam logic [31:0] MOD_P2 = 32'd2000000014;
    localparam logic [31:0] MOD_P3 = 32'd3000000021;

    // Matrices stored as flat register arrays, entry r*3+c.
    logic [29:0] acc_reg [9];
    logic [29:0] acc_next [9];
    logic [29:0] base_reg [9];
    logic [29:0] base_next [9];
    logic [29:0] tmp_reg [9];
    logic [29:0] tmp_next [9];

    // Sequence: for each of 9 entries, 3 terms -> 27 MAC steps; the final reduction does one entry.
    logic        busy_reg, busy_next;
    logic [1:0]  row_reg, row_next;
    logic [1:0]  col_reg, col_next;
    logic [1:0]  k_reg, k_next;
    logic        sqr_reg, sqr_next;
    logic        fin_reg, fin_next;
    logic [29:0] sum_reg, sum_next;
    logic [29:0] res_reg, res_next;

    // Pipeline: operand select -> product -> quotient estimate -> remainder
    // -> fold and accumulate.
    logic [59:0] prod_reg, prod_next;
    logic        pv_reg, pv_next;
    logic        plast_reg, plast_next;
    logic        pfirst_reg, pfirst_next;
    logic        pdone_reg, pdone_next;
    logic [3:0]  pent_reg, pent_next;
    logic        issue_done_reg, issue_done_next;

    logic [61:0] quot_reg, quot_next;
    logic [31:0] low_reg, low_next;
    logic        qv_reg;
    logic        qlast_reg;
    logic        qfirst_reg;
    logic        qdone_reg;
    logic [3:0]  qent_reg;

    logic [31:0] rem_reg, rem_next;
    logic        rv_reg;
    logic        rlast_reg;
    logic        rfirst_reg;
    logic        rdone_reg;
    logic [3:0]  rent_reg;

    logic [3:0]  ent;
    logic [3:0]  ia, ib;
    logic [29:0] opa, opb;
    logic [31:0] qp_lo;
    logic [29:0] red;
    logic [30:0] add;
    logic [29:0] addm;

    // Barrett reduction of the 60-bit product over two register stages.
    // The estimated quotient is at most two short, so the remainder on the
    // low 32 bits lands below 3p and two compares finish it.
    always_comb
    begin
        quot_next = 62'(prod_reg[59:29]) * 62'(BAR_M);
        low_next  = prod_reg[31:0];
        qp_lo     = 32'(quot_reg[61:31]) * 32'(MOD_P);
        rem_next  = low_reg - qp_lo;
        if (rem_reg >= MOD_P2)
        begin
            red = 30'(rem_reg - MOD_P2);
        end
        else if (rem_reg >= 32'(MOD_P))
        begin
            red = 30'(rem_reg - 32'(MOD_P));
        end
        else
        begin
            red = rem_reg[29:0];
        end
    end

    always_comb
    begin
        ent = {2'b00, row_reg} * 4'd3 + {2'b00, col_reg};
        if (sqr_reg)
        begin
            ia = {2'b00, row_reg} * 4'd3 + {2'b00, k_reg};
            ib = {2'b00, k_reg} * 4'd3 + {2'b00, col_reg};
            opa = base_reg[ia];
            opb = base_reg[ib];
        end
        else if (fin_reg)
        begin
            ia = 4'd6 + {2'b00, k_reg};
            ib = 4'd0;
            opa = acc_reg[ia];
            opb = (k_reg == 2'd2) ? 30'd2 : 30'd1;
        end
        else
        begin
            ia = {2'b00, row_reg} * 4'd3 + {2'b00, k_reg};
            ib = {2'b00, k_reg} * 4'd3 + {2'b00, col_reg};
            opa = acc_reg[ia];
            opb = base_reg[ib];
        end
        add  = 31'(rfirst_reg ? 30'd0 : sum_reg) + 31'(red);
        addm = (add >= 31'(MOD_P)) ? 30'(add - 31'(MOD_P)) : add[29:0];
    end

    always_comb
    begin
        acc_next = acc_reg;
        base_next = base_reg;
        tmp_next = tmp_reg;
        busy_next = busy_reg;
        row_next = row_reg;
        col_next = col_reg;
        k_next = k_reg;
        sqr_next = sqr_reg;
        fin_next = fin_reg;
        sum_next = sum_reg;
        res_next = res_reg;
        prod_next = 60'(opa) * 60'(opb);
        pv_next = 1'b0;
        plast_next = 1'b0;
        pdone_next = 1'b0;
        pfirst_next = (k_reg == 2'd0);
        pent_next = ent;
        issue_done_next = issue_done_reg;

        if (cmd.start)
        begin
            case (cmd.op)
                OP_INIT:
                begin
                    for (int i = 0; i < 9; i++)
                    begin
                        acc_next[i] = (i == 0 || i == 4 || i == 8) ? 30'd1 : 30'd0;
                    end
                    base_next[0] = 30'd0; base_next[1] = 30'd1; base_next[2] = 30'd0;
                    base_next[3] = 30'd1; base_next[4] = 30'd1; base_next[5] = 30'd0;
                    base_next[6] = 30'd1; base_next[7] = 30'd1; base_next[8] = 30'd1;
                end
                OP_MUL, OP_SQR:
                begin
                    busy_next = 1'b1;
                    sqr_next = (cmd.op == OP_SQR);
                    fin_next = cmd.fin;
                    row_next = 2'd0;
                    col_next = 2'd0;
                    k_next = 2'd0;
                    issue_done_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else if (busy_reg && !issue_done_reg)
        begin
            pv_next = 1'b1;
            plast_next = (k_reg == 2'd2);
            if (k_reg == 2'd2)
            begin
                k_next = 2'd0;
                if (fin_reg || (row_reg == 2'd2 && col_reg == 2'd2))
                begin
                    issue_done_next = 1'b1;
                    pdone_next = 1'b1;
                end
                else if (col_reg == 2'd2)
                begin
                    col_next = 2'd0;
                    row_next = row_reg + 2'd1;
                end
                else
                begin
                    col_next = col_reg + 2'd1;
                end
            end
            else
            begin
                k_next = k_reg + 2'd1;
            end
        end

        if (rv_reg)
        begin
            sum_next = addm;
            if (rlast_reg)
            begin
                if (fin_reg)
                begin
                    res_next = addm;
                end
                else
                begin
                    tmp_next[rent_reg] = addm;
                end
                if (rdone_reg)
                begin
                    // Last entry done: commit the product, or only the result for the final reduction.
                    busy_next = 1'b0;
                    if (!fin_reg)
                    begin
                        for (int i = 0; i < 9; i++)
                        begin
                            if (sqr_reg)
                            begin
                                base_next[i] = (4'(i) == rent_reg) ? addm : tmp_reg[i];
                            end
                            else
                            begin
                                acc_next[i] = (4'(i) == rent_reg) ? addm : tmp_reg[i];
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pv_reg <= 1'b0;
            qv_reg <= 1'b0;
            rv_reg <= 1'b0;
            issue_done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pv_reg <= pv_next;
            qv_reg <= pv_reg;
            rv_reg <= qv_reg;
            issue_done_reg <= issue_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        base_reg <= base_next;
        tmp_reg <= tmp_next;
        row_reg <= row_next;
        col_reg <= col_next;
        k_reg <= k_next;
        sqr_reg <= sqr_next;
        fin_reg <= fin_next;
        sum_reg <= sum_next;
        res_reg <= res_next;
        prod_reg <= prod_next;
        plast_reg <= plast_next;
        pfirst_reg <= pfirst_next;
        pdone_reg <= pdone_next;
        pent_reg <= pent_next;
        quot_reg <= quot_next;
        low_reg <= low_next;
        qlast_reg <= plast_reg;
        qfirst_reg <= pfirst_reg;
        qdone_reg <= pdone_reg;
        qent_reg <= pent_reg;
        rem_reg <= rem_next;
        rlast_reg <= qlast_reg;
        rfirst_reg <= qfirst_reg;
        rdone_reg <= qdone_reg;
        rent_reg <= qent_reg;
    end

    assign sts.busy = busy_reg;
    assign result = res_reg;

    `FPS_ASSERT_SAME(a_sum_range, clk, rst_n, rv_reg, sum_reg < MOD_P || rfirst_reg)
    `FPS_ASSERT_SAME(a_rem_range, clk, rst_n, rv_reg, rem_reg < MOD_P3)
    `FPS_ASSERT_NEXT(a_no_issue_idle, clk, rst_n, !busy_reg && !cmd.start, !pv_reg)
    `FPS_ASSERT_NEXT(a_res_range, clk, rst_n, rv_reg && rlast_reg && fin_reg, res_reg < MOD_P)
endmodule

// ----- hw/rtl/fps_ctrl.sv -----
`timescale 1ns / 1ps
`include "fibonacci_prefix_sum_mod_defines.svh"
module fps_ctrl
#(
    parameter int unsigned EXP_BITS = fps_pkg::DEF_EXP_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [fps_pkg::IN_W-1:0]  index_n,
    output logic                      out_valid,
    input  logic                      out_stall,
    output fps_pkg::fps_cmd_t         cmd,
    input  fps_pkg::fps_sts_t         sts
);
    import fps_pkg::*;
    localparam int unsigned CW = $clog2(EXP_BITS + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SQR  = 6'b000100,
        S_FIN  = 6'b001000,
        S_WAIT = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [EXP_BITS-1:0] e_reg, e_next;
    logic [CW-1:0] bit_reg, bit_next;
    logic launched_reg, launched_next;
    logic [IN_W-1:0] nm1;

    assign nm1 = (index_n == '0) ? '0 : index_n - IN_W'(1);

    always_comb
    begin
        state_next = state_reg;
        e_next = e_reg;
        bit_next = bit_reg;
        launched_next = launched_reg;
        cmd = '{op: OP_NONE, start: 1'b0, fin: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    e_next = EXP_BITS'({1'b0, nm1});
                    bit_next = '0;
                    cmd = '{op: OP_INIT, start: 1'b1, fin: 1'b0};
                    state_next = S_MUL;
                    launched_next = 1'b0;
                end
            end
            S_MUL, S_SQR, S_FIN:
            begin
                if (!launched_reg)
                begin
                    if (state_reg == S_MUL && !e_reg[0])
                    begin
                        state_next = S_SQR;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        cmd.op = (state_reg == S_SQR) ? OP_SQR : OP_MUL;
                        cmd.fin = (state_reg == S_FIN);
                        launched_next = 1'b1;
                    end
                end
                else if (!sts.busy)
                begin
                    launched_next = 1'b0;
                    case (state_reg)
                        S_MUL: state_next = S_SQR;
                        S_SQR:
                        begin
                            e_next = e_reg >> 1;
                            bit_next = bit_reg + CW'(1);
                            state_next = (bit_reg == CW'(EXP_BITS - 1) || e_next == '0)
                                ? S_FIN : S_MUL;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            launched_reg <= launched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
        bit_reg <= bit_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    `FPS_ASSERT_NEXT(a_accept_start, clk, rst_n, in_valid && !in_stall, state_reg == S_MUL)
    `FPS_ASSERT_SAME(a_one_launch, clk, rst_n, cmd.start && cmd.op != OP_INIT, !sts.busy)
    `FPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule

// ----- hw/rtl/fibonacci_prefix_sum_mod.sv -----
`timescale 1ns / 1ps
// Sum of Fibonacci numbers F(1)..F(n+1) modulo 1000000007.
// Input channel: in_valid / in_stall with index_n (63 bits, n >= 1; zero
// behaves as one). Output channel: out_valid / out_stall with sum_mod.
// One item at a time: in_stall is high from acceptance until the result
// has been taken. The controller scans the exponent n-1 from its least
// significant bit; each bit costs one optional 3x3 multiply and one square.
// Each 3x3 modular product issues 27 steps on one shared 30x30 multiplier,
// then drains the product and Barrett reduction stages and commits. A zero
// bit skips its multiply, and the final row product reduces only the bottom
// row against the start vector. The scan stops after the highest set bit of
// the exponent, and a new index is accepted only after the last sum is taken.
// Reset clears the controller to idle; no state survives between items.
// While the receiver stalls, sum_mod holds and no new item is taken.
module fibonacci_prefix_sum_mod
#(
    parameter int unsigned EXP_BITS = fps_pkg::DEF_EXP_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [fps_pkg::IN_W-1:0] index_n,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [fps_pkg::OUT_W-1:0] sum_mod
);
    import fps_pkg::*;

    fps_cmd_t cmd;
    fps_sts_t sts;

    // Controller: exponent scan and handshakes.
    fps_ctrl #(.EXP_BITS(EXP_BITS)) u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .index_n(index_n),
        .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .sts(sts)
    );

    // Datapath: matrices and the shared modular multiplier.
    fps_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n),
        .cmd(cmd), .sts(sts), .result(sum_mod)
    );
endmodule

// ----- dv/fibonacci_prefix_sum_mod_tb.sv -----
`timescale 1ns / 1ps

module fibonacci_prefix_sum_mod_tb;

    import fps_pkg::*;

    localparam longint unsigned PRIME      = 64'd1000000007;
    localparam int              N_RANDOM   = 120;
    localparam int              N_QUIET    = 20;
    localparam int              STALL_HOLD = 250;
    // Watchdog idle limit: must cover the worst item plus receiver stalls.
    localparam int              WDOG_LIMIT = 20000;
    localparam int              DRAIN_WAIT = 100;

    typedef longint unsigned mat3_t [3][3];

    // Sum-of-Fibonacci predictor and store of pending sums.
    class FibSumBoard;
        bit [OUT_W-1:0] sums_due[$];
        int             errors;

        function automatic mat3_t mul_mod(mat3_t a, mat3_t b);
            mat3_t r;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    r[i][j] = 0;
                    for (int k = 0; k < 3; k++)
                    begin
                        r[i][j] = (r[i][j] + (a[i][k] * b[k][j]) % PRIME) % PRIME;
                    end
                end
            end
            return r;
        endfunction

        function automatic bit [OUT_W-1:0] fib_sum(bit [IN_W-1:0] n);
            mat3_t          pwr;
            mat3_t          step;
            longint unsigned ex;
            longint unsigned s;
            pwr  = '{'{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}};
            step = '{'{0, 1, 0}, '{1, 1, 0}, '{1, 1, 1}};
            // Zero behaves as one: exponent zero, identity power.
            ex = (n == 0) ? 0 : 64'(n) - 1;
            for (int i = 0; i < DEF_EXP_BITS; i++)
            begin
                if (ex[i])
                    pwr = mul_mod(pwr, step);
                step = mul_mod(step, step);
            end
            // Apply the bottom row to the start vector (1, 1, 2).
            s = (pwr[2][0] + pwr[2][1]) % PRIME;
            s = (s + (pwr[2][2] * 2) % PRIME) % PRIME;
            return s[OUT_W-1:0];
        endfunction

        function void note_index(bit [IN_W-1:0] n);
            sums_due = {sums_due, fib_sum(n)};
        endfunction

        function void check_sum(bit [OUT_W-1:0] got);
            bit [OUT_W-1:0] want;
            if (sums_due.size() == 0)
            begin
                $display("%0t: unexpected sum_mod %0d", $time, got);
                errors++;
                return;
            end
            want = sums_due.pop_front();
            if (got !== want)
            begin
                $display("%0t: sum_mod mismatch, expected %0d actual %0d", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return sums_due.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [IN_W-1:0]   index_n;
    logic              out_valid;
    logic              out_stall;
    logic [OUT_W-1:0]  sum_mod;

    FibSumBoard board;
    bit         quiet;      // no idling in the last part of the run
    bit         hold_armed; // request one long receiver hold-off
    int         idle_count;

    fibonacci_prefix_sum_mod i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .index_n   (index_n),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sum_mod   (sum_mod)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Offer one index and hold it until the block takes it.
    task automatic send_index(bit [IN_W-1:0] n);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            in_valid = 1'b0;
            index_n  = IN_W'($urandom());
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        index_n  = n;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        board.note_index(n);
    endtask

    // Pause the sender until every pending sum has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Random index: mostly short exponents to keep latency down, some full width.
    function automatic bit [IN_W-1:0] rand_index();
        bit [63:0] raw;
        int        w;
        raw = {$urandom(), $urandom()};
        w   = ($urandom_range(0, 3) == 0) ? IN_W : $urandom_range(1, 20);
        if (w < IN_W)
            raw = raw & ((64'd1 << w) - 1);
        return raw[IN_W-1:0];
    endfunction

    // Receiver: pick stall at the falling edge, take results at the rising edge.
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = STALL_HOLD;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(0, 2))
                begin
                    @(posedge clk);
                    @(negedge clk);
                end
            end
            else
            begin
                out_stall = 1'b0;
            end
            @(posedge clk);
            if (out_valid && !out_stall)
                board.check_sum(sum_mod);
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_count <= 0;
        else
        begin
            idle_count <= idle_count + 1;
            if (idle_count >= WDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        bit [IN_W-1:0] directed[$];
        board      = new();
        quiet      = 1'b0;
        hold_armed = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        index_n    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Index one, index zero, small steps, the prime, single high bits, alternating bits, all ones.
        directed = '{63'd1, 63'd0, 63'd2, 63'd3, 63'd4, 63'd5, 63'd10, 63'd63, 63'd64,
                     63'd65, 63'd1000000007, 63'd1000000008, 63'h7FFF_FFFF,
                     63'h8000_0000, 63'h4000_0000_0000_0000, 63'h4000_0000_0000_0001,
                     63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555,
                     63'h7FFF_FFFF_FFFF_FFFE, 63'h7FFF_FFFF_FFFF_FFFF};
        foreach (directed[i])
            send_index(directed[i]);

        // Pause the sender until everything is back.
        wait_drained();

        // Hold the receiver off while the sender keeps offering short items,
        // so a finished sum waits and the input stays stalled.
        hold_armed = 1'b1;
        for (int i = 0; i < 6; i++)
            send_index(IN_W'($urandom_range(1, 4)));

        for (int i = 0; i < N_RANDOM - 6; i++)
        begin
            if (i == N_RANDOM - 6 - N_QUIET)
                quiet = 1'b1;
            send_index(rand_index());
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/fps_pkg.sv
hw/rtl/fps_datapath.sv
hw/rtl/fps_ctrl.sv
hw/rtl/fibonacci_prefix_sum_mod.sv
dv/fibonacci_prefix_sum_mod_tb.sv
